// File: hw/rtl/lss_pkg.sv
package lss_pkg;

    localparam int DATA_W        = 32;
    localparam int MODE_W        = 2;
    localparam int COUNT_OUT_W   = 8;
    localparam int M_TDATA_W     = 48;
    localparam int DEPTH_DEFAULT = 128;
    localparam int GROUP_W       = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH     = 2'd0,
        MODE_POP      = 2'd1,
        MODE_PEEK     = 2'd2,
        MODE_CONTAINS = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_REDUCE
    } fsm_state_t;

    // Shift command broadcast to every cell of the stack row.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/lifo_stack_with_search.sv
// Channel   Dir  Ports                     Content
// s_ input  in   s_tvalid/s_tready         s_tdata: operand; s_tuser: mode
// m_ result out  m_tvalid/m_tready         m_tdata: read_value, found, status,
//                                          count, is_empty
//
// Push, pop and peek finish in the accept cycle: the result is in the output
// register in the cycle after the request. Contains passes its registers in
// turn: every cell compares its entry in parallel and registers a hit, a
// registered OR per group of cells follows, then the final OR loads the output
// register. Reset (aresetn low, synchronous) empties the stack; cell contents
// are left as they are and are never read unless pushed since. One request is
// in work at a time; a new one is taken while the output register is free or
// being drained, so a stalled m_tready holds the input side after one result.
module lifo_stack_with_search #(
    parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lss_pkg::DATA_W-1:0]     s_tdata,  // [31:0] operand
    input  logic [lss_pkg::MODE_W-1:0]     s_tuser,  // [1:0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] read_value, [32] found, [34:33] status, [42:35] count,
    // [43] is_empty, [47:44] zero
    output logic [lss_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lss_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Control state
    fsm_state_t           state_reg;
    fsm_state_t           state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    // Request decode
    logic                 accept;
    mode_t                mode;
    logic                 is_empty_now;
    logic                 is_full_now;
    cell_ctrl_t           ctrl;

    // Result of a push, pop or peek
    logic [DATA_W-1:0]    res_value;
    status_t              res_status;
    logic                 load_direct;
    logic                 load_search;

    // Cell row: cell 0 is the top of the stack
    logic [DATA_W-1:0]    entries [DEPTH];
    logic [DEPTH-1:0]     hits;
    logic                 any_hit;

    assign accept       = s_tvalid && s_tready;
    assign mode         = mode_t'(s_tuser);
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == FULL_COUNT);

    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        res_value  = '0;
        res_status = ST_OK;
        unique case (mode)
            MODE_PUSH: begin
                if (is_full_now) begin
                    res_status = ST_OVERFLOW;
                end else begin
                    ctrl.push  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP: begin
                if (is_empty_now) begin
                    res_status = ST_UNDERFLOW;
                end else begin
                    ctrl.pop   = accept;
                    res_value  = entries[0];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            MODE_PEEK: begin
                if (is_empty_now) begin
                    res_status = ST_UNDERFLOW;
                end else begin
                    res_value = entries[0];
                end
            end
            MODE_CONTAINS: begin
                // Leave the stack as it is; the answer comes from the hit tree.
            end
            default: begin
            end
        endcase
    end

    // Cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] above;
        logic [DATA_W-1:0] below;

        if (i == 0) begin : g_top
            assign above = s_tdata;
        end else begin : g_mid
            assign above = entries[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign below = entries[i];
        end else begin : g_inner
            assign below = entries[i+1];
        end

        lss_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .from_above (above),
            .from_below (below),
            .key        (s_tdata),
            .count      (count_reg),
            .entry      (entries[i]),
            .hit        (hits[i])
        );
    end

    lss_hit_reduce #(
        .DEPTH (DEPTH)
    ) u_reduce (
        .aclk    (aclk),
        .hits    (hits),
        .any_hit (any_hit)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept && (mode == MODE_CONTAINS)) begin
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH: begin
                state_next = FSM_REDUCE;
            end
            FSM_REDUCE: begin
                state_next = FSM_IDLE;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_tready    = 1'b0;
        load_search = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_tready = !m_valid_reg || m_tready;
            end
            FSM_SEARCH: begin
            end
            FSM_REDUCE: begin
                load_search = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign load_direct = accept && (mode != MODE_CONTAINS);

    // Output register
    always_comb begin
        logic [CNT_W+COUNT_OUT_W-1:0] count_wide;
        count_wide   = '0;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (load_direct) begin
            count_wide   = (CNT_W+COUNT_OUT_W)'(count_next);
            m_valid_next = 1'b1;
            m_data_next  = {4'b0, (count_next == '0), count_wide[COUNT_OUT_W-1:0],
                            res_status, 1'b0, res_value};
        end else if (load_search) begin
            count_wide   = (CNT_W+COUNT_OUT_W)'(count_reg);
            m_valid_next = 1'b1;
            m_data_next  = {4'b0, is_empty_now, count_wide[COUNT_OUT_W-1:0],
                            ST_OK, any_hit, {DATA_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= accept ? count_next : count_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: hw/rtl/lss_cell.sv
module lss_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                          aclk,
    input  lss_pkg::cell_ctrl_t           ctrl,
    input  logic [lss_pkg::DATA_W-1:0]    from_above,
    input  logic [lss_pkg::DATA_W-1:0]    from_below,
    input  logic [lss_pkg::DATA_W-1:0]    key,
    input  logic [CNT_W-1:0]              count,
    output logic [lss_pkg::DATA_W-1:0]    entry,
    output logic                          hit
);
    import lss_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              hit_reg;
    logic              hit_next;
    logic              occupied;

    // Cell IDX holds an entry while IDX is below the fill count.
    assign occupied = count > CNT_W'(IDX);

    always_comb begin
        priority if (ctrl.push) begin
            entry_next = from_above;
        end else if (ctrl.pop) begin
            entry_next = from_below;
        end else begin
            entry_next = entry_reg;
        end
    end

    assign hit_next = occupied && (entry_reg == key);

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// File: hw/rtl/lss_hit_reduce.sv
module lss_hit_reduce #(
    parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic [DEPTH-1:0] hits,
    output logic             any_hit
);
    import lss_pkg::*;

    localparam int NGROUP = (DEPTH + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W  = NGROUP * GROUP_W;

    logic [PAD_W-1:0]  hits_pad;
    logic [NGROUP-1:0] group_reg;
    logic [NGROUP-1:0] group_next;

    assign hits_pad = PAD_W'(hits);

    // First level: one OR per group of cells, registered.
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            group_next[g] = |hits_pad[g*GROUP_W +: GROUP_W];
        end
    end

    always_ff @(posedge aclk) begin
        group_reg <= group_next;
    end

    assign any_hit = |group_reg;

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lss_pkg::*;

    localparam int STACK_DEPTH  = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1525;
    // the tail of the random part runs with both sides always ready
    localparam int QUIET_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 160;
    // contains is the slowest request: it passes the hit, group and output registers
    localparam int DRAIN_CYCLES = 16;

    typedef enum {
        PH_FILL,
        PH_OVERRUN,
        PH_DRAIN,
        PH_UNDERRUN,
        PH_MIX
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0]      read_value;
        logic                   found;
        status_t                status;
        logic [COUNT_OUT_W-1:0] count;
        logic                   is_empty;
    } stack_result_t;

    // Stack image plus the queue of results still owed by the block.
    class stack_scoreboard;
        logic [DATA_W-1:0] cells [STACK_DEPTH];
        int unsigned       held = 0;
        stack_result_t     owed_q[$];
        int                mismatches = 0;

        function void note_request(mode_t op, logic [DATA_W-1:0] operand);
            stack_result_t r;
            int unsigned   i;
            r = '{read_value: '0, found: 1'b0, status: ST_OK, count: '0, is_empty: 1'b0};
            case (op)
                MODE_PUSH: begin
                    if (held == STACK_DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        cells[held] = operand;
                        held++;
                    end
                end
                MODE_POP: begin
                    if (held == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        held--;
                        r.read_value = cells[held];
                    end
                end
                MODE_PEEK: begin
                    if (held == 0) r.status = ST_UNDERFLOW;
                    else r.read_value = cells[held-1];
                end
                default: begin
                    for (i = 0; i < held; i++) begin
                        if (cells[i] == operand) r.found = 1'b1;
                    end
                end
            endcase
            r.count    = COUNT_OUT_W'(held);
            r.is_empty = (held == 0);
            owed_q.push_back(r);
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("%t mismatch: %s", $realtime, what);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            stack_result_t want;
            stack_result_t got;
            got.read_value = word[31:0];
            got.found      = word[32];
            got.status     = status_t'(word[34:33]);
            got.count      = word[42:35];
            got.is_empty   = word[43];
            if (owed_q.size() == 0) begin
                flag($sformatf("result with nothing outstanding, tdata %h", word));
                return;
            end
            want = owed_q.pop_front();
            if (got.read_value !== want.read_value || got.found !== want.found ||
                got.status !== want.status || got.count !== want.count ||
                got.is_empty !== want.is_empty || word[M_TDATA_W-1:44] !== '0) begin
                flag($sformatf({"expected value %h found %b status %0d count %0d empty %b,",
                                " got value %h found %b status %0d count %0d empty %b pad %h"},
                               want.read_value, want.found, want.status, want.count,
                               want.is_empty, got.read_value, got.found, got.status,
                               got.count, got.is_empty, word[M_TDATA_W-1:44]));
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function logic [DATA_W-1:0] pick_held();
            return cells[$urandom_range(0, held - 1)];
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata  = '0;
    logic [MODE_W-1:0]      s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    stack_scoreboard sb = new;
    bit              idle_enabled = 1'b1;
    bit              hold_off_req = 1'b0;
    int              random_sent  = 0;

    lifo_stack_with_search i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Offer one request and hold it until the block takes it. On return we sit at the
    // accepting edge with s_tvalid still high, so the caller must either drive the next
    // request or lower s_tvalid in this same step.
    task automatic send_request(input mode_t op, input logic [DATA_W-1:0] operand);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= operand;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, operand);
    endtask

    // Lower s_tvalid and wait until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Mostly random words, some small values so that pushes repeat and searches hit,
    // the sign and all-ones corners, and stored entries for searches that must hit.
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 15);
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return (sb.held > 0) ? sb.pick_held() : $urandom;
        endcase
    endfunction

    // Weight the operation by phase: fill and drain walk the stack to its ends,
    // overrun and underrun hit the full and empty cases, mix stays in the middle.
    function automatic mode_t choose_mode(phase_t ph);
        int w;
        w = $urandom_range(0, 99);
        case (ph)
            PH_FILL:     return w < 70 ? MODE_PUSH : w < 80 ? MODE_CONTAINS :
                                w < 90 ? MODE_PEEK : MODE_POP;
            PH_OVERRUN:  return w < 80 ? MODE_PUSH : MODE_CONTAINS;
            PH_DRAIN:    return w < 60 ? MODE_POP : w < 75 ? MODE_PEEK :
                                w < 88 ? MODE_CONTAINS : MODE_PUSH;
            PH_UNDERRUN: return w < 50 ? MODE_POP : w < 80 ? MODE_PEEK : MODE_CONTAINS;
            default:     return w < 35 ? MODE_PUSH : w < 60 ? MODE_POP :
                                w < 80 ? MODE_PEEK : MODE_CONTAINS;
        endcase
    endfunction

    task automatic random_item(input phase_t ph);
        random_sent++;
        idle_enabled = (random_sent < RANDOM_ITEMS - QUIET_ITEMS);
        // ask the receiver for a long stall while we keep offering requests
        if (random_sent == 300) hold_off_req = 1'b1;
        send_request(choose_mode(ph), pick_operand());
        // pause the input until the output side has caught up
        if (random_sent == 700) wait_drained();
    endtask

    // Stimulus: reset, directed corners, then phased random traffic.
    initial begin
        phase_t next_mix;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // underflow and a miss on the empty stack
        send_request(MODE_POP, 32'h1234_5678);
        send_request(MODE_PEEK, 32'hffff_ffff);
        send_request(MODE_CONTAINS, 32'h0000_0000);
        // push the corners of the operand range
        send_request(MODE_PUSH, 32'h8000_0000);
        send_request(MODE_PUSH, 32'h7fff_ffff);
        send_request(MODE_PUSH, 32'h0000_0000);
        send_request(MODE_PUSH, 32'hffff_ffff);
        send_request(MODE_PUSH, 32'h5555_5555);
        send_request(MODE_PUSH, 32'haaaa_aaaa);
        // hits at top, middle and bottom; near misses
        send_request(MODE_CONTAINS, 32'haaaa_aaaa);
        send_request(MODE_CONTAINS, 32'h0000_0000);
        send_request(MODE_CONTAINS, 32'h8000_0000);
        send_request(MODE_CONTAINS, 32'haaaa_aaab);
        send_request(MODE_CONTAINS, 32'h7fff_fffe);
        send_request(MODE_PEEK, 32'h0000_0000);
        send_request(MODE_POP, 32'h0000_0000);
        // the popped value must no longer be found
        send_request(MODE_CONTAINS, 32'haaaa_aaaa);
        send_request(MODE_PEEK, 32'h0000_0000);
        send_request(MODE_POP, 32'hffff_ffff);
        send_request(MODE_POP, 32'h0000_0000);
        send_request(MODE_POP, 32'h0000_0000);
        send_request(MODE_POP, 32'h0000_0000);
        send_request(MODE_POP, 32'h0000_0000);
        send_request(MODE_POP, 32'h0000_0000);
        send_request(MODE_CONTAINS, 32'h8000_0000);

        // Fill to the top, push past it, wander, then empty and pop past the bottom.
        // Stop as soon as the random budget is spent, even inside a phase.
        next_mix = PH_FILL;
        while (random_sent < RANDOM_ITEMS) begin
            if (next_mix == PH_FILL) begin
                while (sb.held < STACK_DEPTH && random_sent < RANDOM_ITEMS)
                    random_item(PH_FILL);
                repeat ($urandom_range(1, 4))
                    if (random_sent < RANDOM_ITEMS) random_item(PH_OVERRUN);
                next_mix = PH_DRAIN;
            end else begin
                while (sb.held > 0 && random_sent < RANDOM_ITEMS) random_item(PH_DRAIN);
                repeat ($urandom_range(1, 4))
                    if (random_sent < RANDOM_ITEMS) random_item(PH_UNDERRUN);
                next_mix = PH_FILL;
            end
            repeat ($urandom_range(20, 120))
                if (random_sent < RANDOM_ITEMS) random_item(PH_MIX);
        end

        // drop valid, collect everything owed, then let the pipeline settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("lifo_stack_with_search regression: pass");
        end else begin
            $display("lifo_stack_with_search regression: fail");
        end
        $finish;
    end

    // Receiver: random ready bursts and stalls, plus one long hold-off on request.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_enabled && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                // now and then a long stretch of steady ready
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(30, 60)) @(posedge aclk);
                else repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Check every result taken at an edge against the oldest owed one.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("lifo_stack_with_search regression: fail");
        $finish;
    end

endmodule
